// File: hdl/psmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psmn_pkg
// Shared types and constants of the packed symmetric matrix norm block.
// ----------------------------------------------------------------------------
package psmn_pkg;

    localparam int MAX_ORDER_DEF    = 64;
    localparam int ELEMENT_BITS_DEF = 32;

    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 38;
    localparam int SQ_W      = 60;
    localparam int ORDER_W   = 7;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [SQ_W-1:0]  SQ_MAX  = '1;

    // norm kinds
    localparam logic [KIND_W-1:0] KIND_MAX_ABS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FROB    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NORM_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 2'd2;

    localparam logic TRI_UPPER = 1'b0;
    localparam logic TRI_LOWER = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_SCAN,
        ST_ROOT,
        ST_DONE
    } psmn_state_t;

    typedef struct packed {
        logic clear;
        logic add_m;
        logic add_col;
    } psmn_cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/psmn_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psmn_cell
// One row of the matrix: holds the row's absolute sum and passes the running
// maximum of all rows so far on to its neighbor.
// ----------------------------------------------------------------------------
module psmn_cell (
    input  wire logic                        clk,
    input  wire psmn_pkg::psmn_cell_ctrl_t   ctrl,
    input  wire logic [psmn_pkg::SUM_W-1:0]  m_add,
    input  wire logic [psmn_pkg::SUM_W-1:0]  col_add,
    input  wire logic [psmn_pkg::SUM_W-1:0]  scan_in,
    output logic      [psmn_pkg::SUM_W-1:0]  scan_out
);

    logic [psmn_pkg::SUM_W-1:0] sum_reg;
    logic [psmn_pkg::SUM_W-1:0] sum_next;
    logic [psmn_pkg::SUM_W-1:0] scan_reg;
    logic [psmn_pkg::SUM_W-1:0] scan_next;
    logic [psmn_pkg::SUM_W-1:0] base;
    logic [psmn_pkg::SUM_W-1:0] add_a;
    logic [psmn_pkg::SUM_W-1:0] add_b;
    logic [psmn_pkg::SUM_W+1:0] total;

    // all addends are nonnegative, so one clamp matches clamping each step
    always_comb
    begin
        base  = ctrl.clear ? '0 : sum_reg;
        add_a = ctrl.add_m ? m_add : '0;
        add_b = ctrl.add_col ? col_add : '0;
        total = {2'b00, base} + {2'b00, add_a} + {2'b00, add_b};
        if (total[psmn_pkg::SUM_W+1:psmn_pkg::SUM_W] != 2'b00)
        begin
            sum_next = psmn_pkg::SUM_MAX;
        end
        else
        begin
            sum_next = total[psmn_pkg::SUM_W-1:0];
        end
        scan_next = (sum_reg > scan_in) ? sum_reg : scan_in;
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

endmodule
`default_nettype wire

// File: hdl/psmn_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psmn_root
// Truncated square root of a Q.16 sum of squares, giving Q22.16, two radicand
// bits per cycle.
// ----------------------------------------------------------------------------
module psmn_root (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [psmn_pkg::SQ_W-1:0]   radicand,
    output logic                             done,
    output logic      [psmn_pkg::SUM_W-1:0]  root
);

    localparam int X_W   = psmn_pkg::SQ_W + psmn_pkg::FRAC_BITS;
    localparam int ITER  = X_W / 2;
    localparam int R_W   = psmn_pkg::SUM_W;
    localparam int REM_W = R_W + 2;
    localparam int CNT_W = $clog2(ITER);

    logic [X_W-1:0]   x_reg;
    logic [X_W-1:0]   x_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [R_W-1:0]   root_reg;
    logic [R_W-1:0]   root_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;

    always_comb
    begin
        rem_sh    = {rem_reg, x_reg[X_W-1:X_W-2]};
        trial     = (REM_W+2)'({root_reg, 2'b01});
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = {radicand, {psmn_pkg::FRAC_BITS{1'b0}}};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ITER - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[X_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[R_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

// File: hdl/packed_symmetric_matrix_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_symmetric_matrix_norm
// Norm of a symmetric matrix streamed as one packed triangle, column by column.
// ----------------------------------------------------------------------------
// Configure norm_kind, triangle and order through the cfg channel while the
// block is idle; any write restarts matrix position tracking.
// Elements arrive on element/in_valid/in_ready, one per cycle within a matrix,
// and the block tracks row and column itself. A row of MAX_ORDER cells holds
// the per-row absolute sums; the element datapath is a three-stage pipeline.
// After the last element in_ready drops while the result is finished:
//   max-abs and unused kind: once the pipeline has drained,
//   one/infinity norm: after a max scan through the cells,
//   Frobenius: after the root unit, two radicand bits per cycle.
// The norm then moves to the output register, and the next matrix may start
// while it waits on norm_value/out_valid/out_ready. If the receiver stalls
// with a second norm finished, the block holds it and in_ready stays low.
// Reset clears the registers to norm_kind 0, triangle 0, order 1 and drops
// any pending request; cfg_ready is always high.
// ----------------------------------------------------------------------------
module packed_symmetric_matrix_norm #(
    parameter int MAX_ORDER    = psmn_pkg::MAX_ORDER_DEF,
    parameter int ELEMENT_BITS = psmn_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psmn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [psmn_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [ELEMENT_BITS-1:0]    element,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [psmn_pkg::SUM_W-1:0]        norm_value
);

    localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int SUM_W  = psmn_pkg::SUM_W;
    localparam int SQ_W   = psmn_pkg::SQ_W;

    // configuration
    logic [psmn_pkg::KIND_W-1:0]  kind_reg;
    logic                         tri_reg;
    logic [psmn_pkg::ORDER_W-1:0] order_reg;
    logic [IDX_W-1:0]             nm1;

    // position tracking
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] r_next;
    logic [IDX_W-1:0] c_reg;
    logic [IDX_W-1:0] c_next;
    logic             in_acc;
    logic             cfg_acc;
    logic             s0_start;
    logic             s0_col_end;
    logic             s0_last;
    logic [ELEMENT_BITS-1:0] elem_bits;
    logic [ELEMENT_BITS-1:0] s0_m;

    // stage 1
    logic                    s1_valid_reg;
    logic [ELEMENT_BITS-1:0] s1_m_reg;
    logic                    s1_clear_reg;
    logic                    s1_row_en_reg;
    logic                    s1_col_en_reg;
    logic [IDX_W-1:0]        s1_r_reg;
    logic [IDX_W-1:0]        s1_c_reg;
    logic [SUM_W-1:0]        m38;
    logic [SUM_W-1:0]        colp_reg;
    logic [SUM_W-1:0]        colp_next;
    logic [SUM_W-1:0]        colp_eff;
    logic [SUM_W:0]          colp_sum;
    logic [SUM_W-1:0]        rmax_reg;
    logic [SUM_W-1:0]        rmax_next;
    logic [SUM_W-1:0]        rmax_eff;

    // stage 2
    logic              s2_valid_reg;
    logic              s2_clear_reg;
    logic              s2_double_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]   sq;
    logic [SQ_W:0]     sq_add;
    logic [SQ_W-1:0]   sqt_reg;
    logic [SQ_W-1:0]   sqt_next;
    logic [SQ_W-1:0]   sqt_eff;
    logic [SQ_W+1:0]   sqt_sum;

    // control
    psmn_pkg::psmn_state_t state_reg;
    psmn_pkg::psmn_state_t state_next;
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic                  scan_last;
    logic                  drain_done;
    logic                  root_start;
    logic                  root_done;
    logic [SUM_W-1:0]      root_value;
    logic                  res_load;
    logic [SUM_W-1:0]      res_value;
    logic [SUM_W-1:0]      result_reg;
    logic                  out_load;
    logic                  out_valid_reg;
    logic [SUM_W-1:0]      norm_value_reg;

    // cell row
    psmn_pkg::psmn_cell_ctrl_t cell_ctrl [MAX_ORDER];
    logic [SUM_W-1:0]          scan_link [MAX_ORDER+1];

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign in_acc    = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= psmn_pkg::KIND_MAX_ABS;
            tri_reg   <= psmn_pkg::TRI_UPPER;
            order_reg <= psmn_pkg::ORDER_W'(1);
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                psmn_pkg::REG_NORM_KIND: kind_reg  <= cfg_data[psmn_pkg::KIND_W-1:0];
                psmn_pkg::REG_TRIANGLE:  tri_reg   <= cfg_data[0];
                psmn_pkg::REG_ORDER:     order_reg <= cfg_data[psmn_pkg::ORDER_W-1:0];
                default:                 ;
            endcase
        end
    end

    // last row/column index; order zero acts as one, large orders clamp
    always_comb
    begin
        if (order_reg == '0)
        begin
            nm1 = '0;
        end
        else if (int'(order_reg) > MAX_ORDER)
        begin
            nm1 = IDX_W'(MAX_ORDER - 1);
        end
        else
        begin
            nm1 = IDX_W'(order_reg - psmn_pkg::ORDER_W'(1));
        end
    end

    always_comb
    begin
        elem_bits  = element;
        s0_m       = elem_bits[ELEMENT_BITS-1] ? (~elem_bits + ELEMENT_BITS'(1)) : elem_bits;
        s0_start   = (r_reg == '0) && (c_reg == '0);
        s0_col_end = (tri_reg == psmn_pkg::TRI_LOWER) ? (r_reg == nm1) : (r_reg == c_reg);
        s0_last    = (r_reg == nm1) && (c_reg == nm1);
        r_next     = r_reg;
        c_next     = c_reg;
        if (cfg_acc)
        begin
            r_next = '0;
            c_next = '0;
        end
        else if (in_acc)
        begin
            if (s0_last)
            begin
                r_next = '0;
                c_next = '0;
            end
            else if (s0_col_end)
            begin
                c_next = c_reg + IDX_W'(1);
                r_next = (tri_reg == psmn_pkg::TRI_LOWER) ? (c_reg + IDX_W'(1)) : '0;
            end
            else
            begin
                r_next = r_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg        <= '0;
            c_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            colp_reg     <= '0;
            rmax_reg     <= '0;
            sqt_reg      <= '0;
        end
        else
        begin
            r_reg        <= r_next;
            c_reg        <= c_next;
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            colp_reg     <= colp_next;
            rmax_reg     <= rmax_next;
            sqt_reg      <= sqt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_m_reg      <= s0_m;
        s1_clear_reg  <= s0_start;
        s1_row_en_reg <= (r_reg != c_reg);
        s1_col_en_reg <= s0_col_end;
        s1_r_reg      <= r_reg;
        s1_c_reg      <= c_reg;
        prod_reg      <= PROD_W'(s1_m_reg) * PROD_W'(s1_m_reg);
        s2_clear_reg  <= s1_clear_reg;
        s2_double_reg <= s1_row_en_reg;
    end

    // stage 1: running max and column partial
    always_comb
    begin
        m38       = SUM_W'(s1_m_reg);
        colp_eff  = s1_clear_reg ? '0 : colp_reg;
        rmax_eff  = s1_clear_reg ? '0 : rmax_reg;
        colp_sum  = {1'b0, colp_eff} + {1'b0, m38};
        colp_next = colp_reg;
        rmax_next = rmax_reg;
        if (s1_valid_reg)
        begin
            rmax_next = (m38 > rmax_eff) ? m38 : rmax_eff;
            if (s1_col_en_reg)
            begin
                colp_next = '0;
            end
            else
            begin
                colp_next = colp_sum[SUM_W] ? psmn_pkg::SUM_MAX : colp_sum[SUM_W-1:0];
            end
        end
    end

    // stage 2: sum of squares, off-diagonal terms doubled
    always_comb
    begin
        sq       = SQ_W'(prod_reg >> psmn_pkg::FRAC_BITS);
        sq_add   = s2_double_reg ? {sq, 1'b0} : {1'b0, sq};
        sqt_eff  = s2_clear_reg ? '0 : sqt_reg;
        sqt_sum  = {2'b00, sqt_eff} + {1'b0, sq_add};
        sqt_next = sqt_reg;
        if (s2_valid_reg)
        begin
            if (sqt_sum > (SQ_W+2)'(psmn_pkg::SQ_MAX))
            begin
                sqt_next = psmn_pkg::SQ_MAX;
            end
            else
            begin
                sqt_next = sqt_sum[SQ_W-1:0];
            end
        end
    end

    assign scan_link[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ORDER; gi++)
        begin : g_cell
            always_comb
            begin
                cell_ctrl[gi].clear   = s1_valid_reg & s1_clear_reg;
                cell_ctrl[gi].add_m   = s1_valid_reg &
                    ((s1_row_en_reg & (s1_r_reg == IDX_W'(gi))) |
                     (s1_col_en_reg & (s1_c_reg == IDX_W'(gi))));
                cell_ctrl[gi].add_col = s1_valid_reg & s1_col_en_reg &
                    (s1_c_reg == IDX_W'(gi));
            end

            psmn_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[gi]),
                .m_add    (m38),
                .col_add  (colp_eff),
                .scan_in  (scan_link[gi]),
                .scan_out (scan_link[gi+1])
            );
        end
    endgenerate

    psmn_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sqt_reg),
        .done     (root_done),
        .root     (root_value)
    );

    assign drain_done = ~s1_valid_reg & ~s2_valid_reg;
    assign scan_last  = (scan_cnt_reg == IDX_W'(MAX_ORDER - 1));
    assign out_load   = (state_reg == psmn_pkg::ST_DONE) & (~out_valid_reg | out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psmn_pkg::ST_ACCUM:
            begin
                if (in_acc && s0_last)
                begin
                    state_next = psmn_pkg::ST_DRAIN;
                end
            end
            psmn_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    case (kind_reg)
                        psmn_pkg::KIND_ONE:  state_next = psmn_pkg::ST_SCAN;
                        psmn_pkg::KIND_FROB: state_next = psmn_pkg::ST_ROOT;
                        default:             state_next = psmn_pkg::ST_DONE;
                    endcase
                end
            end
            psmn_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = psmn_pkg::ST_DONE;
                end
            end
            psmn_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = psmn_pkg::ST_DONE;
                end
            end
            psmn_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = psmn_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = psmn_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        root_start = 1'b0;
        res_load   = 1'b0;
        res_value  = '0;
        case (state_reg)
            psmn_pkg::ST_ACCUM:
            begin
                in_ready = 1'b1;
            end
            psmn_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    case (kind_reg)
                        psmn_pkg::KIND_MAX_ABS:
                        begin
                            res_load  = 1'b1;
                            res_value = rmax_reg;
                        end
                        psmn_pkg::KIND_ONE:
                        begin
                            res_load = 1'b0;
                        end
                        psmn_pkg::KIND_FROB:
                        begin
                            root_start = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            psmn_pkg::ST_SCAN:
            begin
                res_load  = scan_last;
                res_value = scan_link[MAX_ORDER];
            end
            psmn_pkg::ST_ROOT:
            begin
                res_load  = root_done;
                res_value = root_value;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psmn_pkg::ST_ACCUM;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == psmn_pkg::ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            end
            else
            begin
                scan_cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= res_value;
        end
        if (out_load)
        begin
            norm_value_reg <= result_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign norm_value = norm_value_reg;

endmodule
`default_nettype wire
